// ===== rtl/ess_pkg.sv =====
// Package for the exponential sine sweep generator: field widths, register indices and reset
// values, plus the elaboration-time quarter-wave sine function that builds the sine ROM.
// No dependencies.
`default_nettype none

package ess_pkg;

    localparam int SINE_ADDR_BITS_DEF = 12;

    localparam int PHASE_W     = 48;
    localparam int RATIO_W     = 32;
    localparam int AMP_W       = 15;
    localparam int DUR_W       = 32;
    localparam int EFFORT_W    = 16;
    localparam int SINE_MAG_W  = 15;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 32'h4000_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_INCREMENT = 2'b00,
        REG_GROWTH_RATIO    = 2'b01,
        REG_AMPLITUDE       = 2'b10,
        REG_DURATION_TICKS  = 2'b11
    } cfg_reg_t;

    // sin((pi/2) * j / 2^(addr_bits-2)) in Q1.15, Taylor series in Q30; elaboration only
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned j,
                                                           input int unsigned addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] rnd;
        longint      sum;
        int unsigned n;
        x    = (64'(j) * HALF_PI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q30))
            sum = longint'(ONE_Q30);
        rnd = (64'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        return rnd[SINE_MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/exponential_sine_sweep_generator_unit.sv =====
// Exponential sine sweep generator, top level.
// Depends on ess_pkg (widths, register indices, quarter-wave sine ROM contents).
//
// Usage:
//   tick channel (tick_valid/tick_ready, field restart): one item per output sample.
//   drive channel (drive_valid/drive_ready, fields effort, active): one item per tick.
//   cfg_we/cfg_index/cfg_data write start_increment, growth_ratio, amplitude and
//   duration_ticks; write them only while no tick is in flight.
// Pipeline: an accepted tick is registered in the ROM stage and then in the output register,
//   whose valid flag is drive_valid.
// Throughput: one tick per cycle unless the drive side stalls. The phase and phase step
//   recurrences close combinationally (48-bit add, two 24x32 partial products, saturation);
//   the sine is a quarter-wave ROM with registered read, followed by one amplitude multiply.
// Stall: while drive_ready is low the result is held in the output register and one
//   further tick is still taken into the ROM stage; tick_ready drops only when both are full.
// Reset: sweep inactive, phase, step, count and held effort cleared, growth_ratio = 1.0,
//   other registers zero. Before any restart the block returns effort 0, active 0.
`default_nettype none

module exponential_sine_sweep_generator_unit #(
    parameter int SINE_ADDR_BITS = ess_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [ess_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [ess_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  wire logic                                    tick_valid,
    output logic                                         tick_ready,
    input  wire logic                                    restart,
    output logic                                         drive_valid,
    input  wire logic                                    drive_ready,
    output logic signed [ess_pkg::EFFORT_W-1:0]          effort,
    output logic                                         active
);

    localparam int PW   = ess_pkg::PHASE_W;
    localparam int QTR  = 1 << (SINE_ADDR_BITS - 2);
    localparam int J_W  = SINE_ADDR_BITS - 1;
    localparam int MW   = ess_pkg::SINE_MAG_W;
    localparam int EW   = ess_pkg::EFFORT_W;
    localparam int HALF = PW / 2;

    // configuration
    logic [PW-1:0]                   start_increment_reg;
    logic [ess_pkg::RATIO_W-1:0]     growth_ratio_reg;
    logic [ess_pkg::AMP_W-1:0]       amplitude_reg;
    logic [ess_pkg::DUR_W-1:0]       duration_reg;

    // sweep state
    logic [PW-1:0]                   phase_reg;
    logic [PW-1:0]                   step_reg;
    logic [ess_pkg::DUR_W-1:0]       elapsed_reg;
    logic                            running_reg;
    logic signed [EW-1:0]            held_reg;
    logic signed [EW-1:0]            held_next;

    // ROM stage and output register
    logic                            s1_valid_reg;
    logic                            s1_go_reg;
    logic                            s1_neg_reg;
    logic [MW-1:0]                   qrom_reg;
    logic                            out_valid_reg;
    logic signed [EW-1:0]            effort_reg;
    logic                            active_reg;

    logic                            accept;
    logic                            advance;
    logic [PW-1:0]                   phase_eff;
    logic [PW-1:0]                   step_eff;
    logic [ess_pkg::DUR_W-1:0]       elapsed_eff;
    logic                            go;
    logic [SINE_ADDR_BITS-1:0]       top;
    logic [1:0]                      quad;
    logic [J_W-1:0]                  jlow;
    logic [J_W-1:0]                  jj;
    logic [HALF+ess_pkg::RATIO_W-1:0] prod_hi;
    logic [HALF+ess_pkg::RATIO_W-1:0] prod_lo;
    logic [HALF+ess_pkg::RATIO_W:0]   carry_sum;
    logic [PW+2:0]                   step_raw;
    logic [PW-1:0]                   step_adv;
    logic signed [EW-1:0]            sine_s;
    logic signed [2*EW-1:0]          amp_prod;

    logic [MW-1:0]                   qtab [QTR+1];

    for (genvar g = 0; g <= QTR; g++)
    begin : g_qtab
        localparam logic [MW-1:0] ENTRY = ess_pkg::quarter_sine(g, SINE_ADDR_BITS);
        assign qtab[g] = ENTRY;
    end

    // handshake
    assign advance    = !out_valid_reg || drive_ready;
    assign tick_ready = !s1_valid_reg || advance;
    assign accept     = tick_valid && tick_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_increment_reg <= '0;
            growth_ratio_reg    <= ess_pkg::RATIO_RESET;
            amplitude_reg       <= '0;
            duration_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ess_pkg::cfg_reg_t'(cfg_index))
                ess_pkg::REG_START_INCREMENT: start_increment_reg <= cfg_data[PW-1:0];
                ess_pkg::REG_GROWTH_RATIO:
                    growth_ratio_reg <= cfg_data[ess_pkg::RATIO_W-1:0];
                ess_pkg::REG_AMPLITUDE:       amplitude_reg <= cfg_data[ess_pkg::AMP_W-1:0];
                ess_pkg::REG_DURATION_TICKS:  duration_reg  <= cfg_data[ess_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // tick stage: resolve restart, step the recurrences, form ROM address
    always_comb
    begin
        phase_eff   = restart ? '0 : phase_reg;
        step_eff    = restart ? start_increment_reg : step_reg;
        elapsed_eff = restart ? '0 : elapsed_reg;
        go          = (restart || running_reg) && (elapsed_eff < duration_reg);

        top  = phase_eff[PW-1 -: SINE_ADDR_BITS];
        quad = top[SINE_ADDR_BITS-1 -: 2];
        jlow = {1'b0, top[SINE_ADDR_BITS-3:0]};
        jj   = quad[0] ? (J_W'(QTR) - jlow) : jlow;

        // step * ratio in Q2.30, split at bit 24 as two partial products
        prod_hi   = {{ess_pkg::RATIO_W{1'b0}}, step_eff[PW-1:HALF]}
                  * {{HALF{1'b0}}, growth_ratio_reg};
        prod_lo   = {{ess_pkg::RATIO_W{1'b0}}, step_eff[HALF-1:0]}
                  * {{HALF{1'b0}}, growth_ratio_reg};
        carry_sum = (HALF+ess_pkg::RATIO_W+1)'({prod_hi[5:0], {HALF{1'b0}}})
                  + (HALF+ess_pkg::RATIO_W+1)'(prod_lo);
        step_raw  = (PW+3)'(prod_hi[HALF+ess_pkg::RATIO_W-1:6])
                  + (PW+3)'(carry_sum[HALF+ess_pkg::RATIO_W:30]);
        step_adv  = (step_raw[PW+2:PW] != 3'b000) ? '1 : step_raw[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            step_reg     <= '0;
            elapsed_reg  <= '0;
            running_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_go_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= go ? (phase_eff + step_eff) : phase_eff;
                step_reg     <= go ? step_adv : step_eff;
                elapsed_reg  <= go ? (elapsed_eff + 1'b1) : elapsed_eff;
                running_reg  <= go;
                s1_valid_reg <= 1'b1;
                s1_go_reg    <= go;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // quarter-wave sine ROM, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qrom_reg   <= qtab[jj];
            s1_neg_reg <= quad[1];
        end
    end

    // amplitude scaling; floor division by 2^15 is an arithmetic shift
    always_comb
    begin
        sine_s    = s1_neg_reg ? -$signed({1'b0, qrom_reg}) : $signed({1'b0, qrom_reg});
        amp_prod  = $signed({1'b0, amplitude_reg}) * sine_s;
        held_next = s1_go_reg ? amp_prod[EW+14:15] : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            effort_reg    <= '0;
            active_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                held_reg   <= held_next;
                effort_reg <= held_next;
                active_reg <= s1_go_reg;
            end
        end
    end

    assign drive_valid = out_valid_reg;
    assign effort      = effort_reg;
    assign active      = active_reg;

    a_go_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
        accept && go |=> running_reg && s1_valid_reg && s1_go_reg)
        else $error("running not set after an active tick");

    a_stop_clears_running: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !go |=> !running_reg && !s1_go_reg)
        else $error("running left set after a finished tick");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> s1_valid_reg && out_valid_reg)
        else $error("tick stalled with room in the pipeline");

    a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> effort == held_reg)
        else $error("output effort differs from held effort");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> drive_valid)
        else $error("item lost between ROM stage and output");

endmodule

`default_nettype wire

// ===== sim/exponential_sine_sweep_generator_unit_test.sv =====
// Self-checking testbench for exponential_sine_sweep_generator_unit: a directed table then
// random phases of ticks under random gaps and stalls, checked against an in-bench predictor.
// Depends on ess_pkg and the RTL of the block only.
`default_nettype none

module exponential_sine_sweep_generator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS = ess_pkg::SINE_ADDR_BITS_DEF;
    localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint UNITY_Q30 = 64'd1073741824;

    typedef struct packed {
        logic signed [ess_pkg::EFFORT_W-1:0] effort;
        logic                                active;
    } drive_t;

    typedef struct packed {
        bit     typed;
        drive_t value;
    } tick_note_t;

    typedef enum bit {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        ess_pkg::cfg_reg_t                   which;
        logic [ess_pkg::CFG_DATA_W-1:0]      data;
        bit                                  restart_bit;
        bit                                  typed;
        logic signed [ess_pkg::EFFORT_W-1:0] effort;
        bit                                  active;
    } row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [ess_pkg::CFG_INDEX_W-1:0]      cfg_index;
    logic [ess_pkg::CFG_DATA_W-1:0]       cfg_data;
    logic                                 tick_valid;
    logic                                 tick_ready;
    logic                                 restart;
    logic                                 drive_valid;
    logic                                 drive_ready;
    logic signed [ess_pkg::EFFORT_W-1:0]  effort;
    logic                                 active;

    // predictor copy of the registers and sweep state
    logic [ess_pkg::PHASE_W-1:0]          start_q;
    logic [ess_pkg::RATIO_W-1:0]          ratio_q;
    logic [ess_pkg::AMP_W-1:0]            amp_q;
    logic [ess_pkg::DUR_W-1:0]            dur_q;
    logic [ess_pkg::PHASE_W-1:0]          sweep_phase;
    logic [ess_pkg::PHASE_W-1:0]          sweep_step;
    logic [ess_pkg::DUR_W-1:0]            sweep_count;
    logic                                 sweep_on;
    logic signed [ess_pkg::EFFORT_W-1:0]  sweep_held;

    drive_t     drive_due[$];
    tick_note_t tick_notes[$];
    int         mismatches = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    exponential_sine_sweep_generator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .restart     (restart),
        .drive_valid (drive_valid),
        .drive_ready (drive_ready),
        .effort      (effort),
        .active      (active)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // magnitude of the quarter-wave sine at j/Q of a quarter turn, Q1.15
    function automatic int quarter_mag(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x_sq;
        logic [63:0] term;
        longint      acc;
        logic [63:0] scaled;
        int unsigned k;
        x    = (64'(j) * QUARTER_TURN_Q30) >> (ADDR_BITS - 2);
        x_sq = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 8; k++)
        begin
            term = ((term * x_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > UNITY_Q30)
            acc = UNITY_Q30;
        scaled = (64'(acc) * 64'd32767 + 64'(UNITY_Q30 / 2)) >> 30;
        return int'(scaled);
    endfunction

    function automatic int sine_at(input logic [ADDR_BITS-1:0] idx);
        int unsigned quarter;
        int unsigned j;
        quarter = 1 << (ADDR_BITS - 2);
        j       = 32'(idx[ADDR_BITS-3:0]);
        case (idx[ADDR_BITS-1 -: 2])
            2'd0: return quarter_mag(j);
            2'd1: return quarter_mag(quarter - j);
            2'd2: return -quarter_mag(j);
            default: return -quarter_mag(quarter - j);
        endcase
    endfunction

    // step times Q2.30 ratio, truncated, clamped to 48 bits
    function automatic logic [ess_pkg::PHASE_W-1:0] grown_step(
        input logic [ess_pkg::PHASE_W-1:0] step,
        input logic [ess_pkg::RATIO_W-1:0] ratio);
        logic [79:0] prod;
        prod = ({32'd0, step} * {48'd0, ratio}) >> 30;
        return (prod[79:48] != 0) ? ALL48 : prod[47:0];
    endfunction

    function automatic drive_t sweep_advance(input bit restart_bit);
        drive_t out;
        int     prod;
        int     scaled;
        out.active = 1'b0;
        if (restart_bit)
        begin
            sweep_phase = '0;
            sweep_step  = start_q;
            sweep_count = '0;
            sweep_on    = 1'b1;
        end
        if (sweep_on && sweep_count < dur_q)
        begin
            prod        = int'(amp_q)
                        * sine_at(sweep_phase[ess_pkg::PHASE_W-1 -: ADDR_BITS]);
            scaled      = prod >>> 15;
            sweep_held  = scaled[ess_pkg::EFFORT_W-1:0];
            out.active  = 1'b1;
            sweep_phase = sweep_phase + sweep_step;
            sweep_step  = grown_step(sweep_step, ratio_q);
            sweep_count = sweep_count + 1;
        end
        else
            sweep_on = 1'b0;
        out.effort = sweep_held;
        return out;
    endfunction

    task automatic flag(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : watch
        tick_note_t note;
        drive_t     predicted;
        drive_t     want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ess_pkg::REG_START_INCREMENT:
                        start_q = cfg_data[ess_pkg::PHASE_W-1:0];
                    ess_pkg::REG_GROWTH_RATIO:
                        ratio_q = cfg_data[ess_pkg::RATIO_W-1:0];
                    ess_pkg::REG_AMPLITUDE:
                        amp_q   = cfg_data[ess_pkg::AMP_W-1:0];
                    ess_pkg::REG_DURATION_TICKS:
                        dur_q   = cfg_data[ess_pkg::DUR_W-1:0];
                    default: ;
                endcase
            end
            if (tick_valid && tick_ready)
            begin
                note      = tick_notes.pop_front();
                predicted = sweep_advance(restart);
                drive_due.push_back(note.typed ? note.value : predicted);
            end
            if (drive_valid && drive_ready)
            begin
                if (drive_due.size() == 0)
                    flag($sformatf("unexpected drive item effort %0d active %0b", effort, active));
                else
                begin
                    want = drive_due.pop_front();
                    if (effort !== want.effort)
                        flag($sformatf("effort %0d, expected %0d", effort, want.effort));
                    if (active !== want.active)
                        flag($sformatf("active %0b, expected %0b", active, want.active));
                end
            end
        end
    end

    // drive side back-pressure
    initial
    begin
        drive_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                drive_ready <= 1'b0;
                repeat ($urandom_range(16, 1) - 1) @(negedge clk);
            end
            else
                drive_ready <= 1'b1;
        end
    end

    task automatic send_tick(input bit restart_bit, input tick_note_t note);
        int gap;
        gap = (gap_pct != 0 && $urandom_range(99) < gap_pct) ? $urandom_range(16, 1) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            tick_valid <= 1'b0;
        end
        @(negedge clk);
        tick_valid <= 1'b1;
        restart    <= restart_bit;
        tick_notes.push_back(note);
        do
            @(posedge clk);
        while (!tick_ready);
    endtask

    // hold off the tick channel until every drive item has come back
    task automatic settle();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (drive_due.size() != 0 || tick_notes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input ess_pkg::cfg_reg_t which,
                             input logic [ess_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    row_t plan[$];

    function automatic row_t wr(input ess_pkg::cfg_reg_t which,
                                input logic [ess_pkg::CFG_DATA_W-1:0] value);
        row_t r;
        r = '{ROW_WRITE, which, value, 1'b0, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic row_t tk(input bit restart_bit, input bit typed,
                                input logic signed [ess_pkg::EFFORT_W-1:0] e, input bit a);
        row_t r;
        r = '{ROW_TICK, ess_pkg::REG_START_INCREMENT, '0, restart_bit, typed, e, a};
        return r;
    endfunction

    initial
    begin : stimulus
        tick_note_t                  note;
        logic [47:0]                 start_v;
        logic [ess_pkg::RATIO_W-1:0] ratio_v;
        logic [ess_pkg::AMP_W-1:0]   amp_v;
        logic [ess_pkg::DUR_W-1:0]   dur_v;
        int                          ticks;
        bit                          restart_bit;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = ess_pkg::REG_START_INCREMENT;
        cfg_data   = '0;
        tick_valid = 1'b0;
        restart    = 1'b0;
        start_q    = '0;
        ratio_q    = ess_pkg::RATIO_RESET;
        amp_q      = '0;
        dur_q      = '0;
        sweep_phase = '0;
        sweep_step  = '0;
        sweep_count = '0;
        sweep_on    = 1'b0;
        sweep_held  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // before any restart, then a restart with zero duration
        plan.push_back(tk(1'b0, 1'b1, 16'sd0, 1'b0));
        plan.push_back(tk(1'b1, 1'b1, 16'sd0, 1'b0));
        // quarter-turn steps at full amplitude: 0, peak, 0, trough, then held
        plan.push_back(wr(ess_pkg::REG_START_INCREMENT, 48'h4000_0000_0000));
        plan.push_back(wr(ess_pkg::REG_GROWTH_RATIO, 48'h0000_4000_0000));
        plan.push_back(wr(ess_pkg::REG_AMPLITUDE, 48'h0000_0000_7FFF));
        plan.push_back(wr(ess_pkg::REG_DURATION_TICKS, 48'h0000_0000_0004));
        plan.push_back(tk(1'b1, 1'b1, 16'sd0, 1'b1));
        plan.push_back(tk(1'b0, 1'b1, 16'sd32766, 1'b1));
        plan.push_back(tk(1'b0, 1'b1, 16'sd0, 1'b1));
        plan.push_back(tk(1'b0, 1'b1, -16'sd32767, 1'b1));
        plan.push_back(tk(1'b0, 1'b1, -16'sd32767, 1'b0));
        plan.push_back(tk(1'b0, 1'b1, -16'sd32767, 1'b0));
        // excess data bits dropped, step saturation
        plan.push_back(wr(ess_pkg::REG_DURATION_TICKS, ALL48));
        plan.push_back(wr(ess_pkg::REG_GROWTH_RATIO, ALL48));
        plan.push_back(wr(ess_pkg::REG_START_INCREMENT, ALL48));
        plan.push_back(tk(1'b1, 1'b1, 16'sd0, 1'b1));
        repeat (4) plan.push_back(tk(1'b0, 1'b0, '0, 1'b0));
        // mid-sweep register changes
        plan.push_back(wr(ess_pkg::REG_AMPLITUDE, 48'hFFFF_FFFF_8000));
        plan.push_back(tk(1'b0, 1'b0, '0, 1'b0));
        plan.push_back(wr(ess_pkg::REG_AMPLITUDE, 48'hA5A5_0000_4321));
        plan.push_back(wr(ess_pkg::REG_GROWTH_RATIO, 48'hFFFF_0000_0000));
        plan.push_back(tk(1'b0, 1'b0, '0, 1'b0));
        plan.push_back(tk(1'b0, 1'b0, '0, 1'b0));
        // restart while running
        plan.push_back(tk(1'b1, 1'b0, '0, 1'b0));
        plan.push_back(tk(1'b0, 1'b0, '0, 1'b0));
        plan.push_back(tk(1'b1, 1'b0, '0, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle();
                cfg_write(plan[i].which, plan[i].data);
            end
            else
            begin
                note.typed        = plan[i].typed;
                note.value.effort = plan[i].effort;
                note.value.active = plan[i].active;
                send_tick(plan[i].restart_bit, note);
            end
        end

        note = '0;
        for (int p = 0; p < 17; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    start_v = ALL48;
                    ratio_v = '1;
                    amp_v   = '1;
                    dur_v   = '1;
                end
                1:
                begin
                    start_v = '0;
                    ratio_v = '0;
                    amp_v   = '0;
                    dur_v   = '0;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0: start_v = ($urandom_range(1) != 0) ? ALL48 : rand48();
                        1: start_v = rand48();
                        default: start_v = rand48() >> $urandom_range(47, 8);
                    endcase
                    case ($urandom_range(4))
                        0: ratio_v = $urandom;
                        1: ratio_v = ess_pkg::RATIO_RESET;
                        2: ratio_v = ess_pkg::RATIO_RESET + $urandom_range(1 << 20) - (1 << 19);
                        3: ratio_v = ess_pkg::RATIO_RESET + $urandom_range(1 << 26);
                        default: ratio_v = ess_pkg::RATIO_RESET - $urandom_range(1 << 24);
                    endcase
                    amp_v = ($urandom_range(3) == 0) ? 15'h7FFF : 15'($urandom);
                    case ($urandom_range(5))
                        0: dur_v = $urandom_range(3);
                        1: dur_v = $urandom;
                        default: dur_v = $urandom_range(150, 1);
                    endcase
                end
            endcase
            cfg_write(ess_pkg::REG_START_INCREMENT, start_v);
            cfg_write(ess_pkg::REG_GROWTH_RATIO, {16'($urandom), ratio_v});
            cfg_write(ess_pkg::REG_AMPLITUDE, {33'({$urandom, $urandom}), amp_v});
            cfg_write(ess_pkg::REG_DURATION_TICKS, {16'($urandom), dur_v});

            if (p == 16)
            begin
                gap_pct   = 0;
                stall_pct = 0;
                ticks     = 140;
            end
            else
            begin
                gap_pct   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 10 : 30);
                stall_pct = (p % 4 == 2) ? 0 : ((p % 4 == 3) ? 35 : 12);
                ticks     = 110;
            end
            for (int t = 0; t < ticks; t++)
            begin
                if (t == 0)
                    restart_bit = ($urandom_range(99) < 85);
                else
                    restart_bit = ($urandom_range(59) == 0);
                send_tick(restart_bit, note);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("exponential_sine_sweep_generator_unit verification clean");
        else
            $display("exponential_sine_sweep_generator_unit verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("exponential_sine_sweep_generator_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
